@@ hdl/cal_pkg.sv @@
package cal_pkg;

    // command codes carried in s_tuser
    typedef enum logic [3:0] {
        ACT_INSERT  = 4'd0,
        ACT_REMOVE  = 4'd1,
        ACT_REPLACE = 4'd2,
        ACT_CLEAR   = 4'd3,
        ACT_BEGIN   = 4'd4,
        ACT_END     = 4'd5,
        ACT_NEXT    = 4'd6,
        ACT_PRIOR   = 4'd7,
        ACT_READ    = 4'd8
    } action_t;

    // result status carried in m_tuser
    typedef enum logic [1:0] {
        STS_DONE  = 2'd0,
        STS_FULL  = 2'd1,
        STS_EMPTY = 2'd2,
        STS_BOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_WRITE,
        ST_FETCH,
        ST_LOAD
    } state_t;

    // fixed field widths of the stream words
    localparam int ACT_W     = 4;
    localparam int DATA_W    = 32;
    localparam int STS_W     = 2;
    localparam int IDXO_W    = 4;
    localparam int CNTO_W    = 5;
    localparam int LIMIT_W   = 5;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 48;

    // bit positions inside m_tdata
    localparam int M_WORD_LSB  = 0;
    localparam int M_IDX_LSB   = M_WORD_LSB + DATA_W;
    localparam int M_CNT_LSB   = M_IDX_LSB + IDXO_W;
    localparam int M_EMPTY_BIT = M_CNT_LSB + CNTO_W;
    localparam int M_FULL_BIT  = M_EMPTY_BIT + 1;
    localparam int M_USED_W    = M_FULL_BIT + 1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

endpackage

@@ hdl/cal_ram.sv @@
module cal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/cursor_array_list.sv @@
// cursor_array_list: ordered list of data words with a cursor, kept in a RAM.
// Slave channel: one command word per handshake. s_tuser carries the command
// (insert, remove, replace, clear, beginning, end, next, prior, read only),
// s_tdata the data word used by insert and replace.
// Master channel: one result word per command. m_tuser carries the status,
// m_tdata the cursor word, cursor index, entry count, empty and full flags.
// cfg_wr_en / cfg_wr_data set the capacity limit; write only while idle.
//
// Timing: s_tready is high only in the idle state; the block works on one
// command at a time. All entry moves go through the single RAM port pair;
// each moved entry is read, then written back one slot over.
//   insert : shift reads and writes, then write of the new word, fetch, load
//   remove : shift reads and writes, then fetch, load
//   replace: write, fetch, load;  all other commands: fetch, load
// The block goes back to idle before the next command is taken.
//
// Reset (aresetn low, synchronous): list empty, cursor 0, limit 16, no result
// pending. RAM contents are not cleared; only entries below count are read.
// Stall: the result sits in the output register; the next command can still
// be accepted, and its result waits in the load state until m_tready.
module cursor_array_list #(
    parameter int CAPACITY  = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration: capacity limit
    input  logic                           cfg_wr_en,
    input  logic [cal_pkg::LIMIT_W-1:0]    cfg_wr_data,
    // command channel
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [cal_pkg::S_TDATA_W-1:0]  s_tdata,  // [31:0] data_word
    input  logic [cal_pkg::ACT_W-1:0]      s_tuser,  // [3:0] action
    // result channel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [31:0] cursor_word, [35:32] cursor_index, [40:36] entry_count,
    // [41] list_empty, [42] list_full, [47:43] zero
    output logic [cal_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [cal_pkg::STS_W-1:0]      m_tuser   // [1:0] status
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > cal_pkg::LIMIT_W) ? CNT_W : cal_pkg::LIMIT_W;

    cal_pkg::state_t  state_reg, state_next;
    cal_pkg::action_t act_reg, act_next;
    cal_pkg::status_t status_reg, status_next;

    logic [WORD_BITS-1:0]        word_reg, word_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [IDX_W-1:0]            cursor_reg, cursor_next;
    logic [IDX_W-1:0]            idx_reg, idx_next;
    logic                        up_reg, up_next;   // shift direction
    logic [cal_pkg::LIMIT_W-1:0] limit_reg;

    logic                          m_valid_reg, m_valid_next;
    logic [cal_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic [cal_pkg::STS_W-1:0]     m_user_reg, m_user_next;

    // RAM port
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr, ram_raddr;
    logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

    // ---------------- shared flags and the index step unit ----------------
    logic [CMP_W-1:0] limit_ext, cap_ext, eff_limit, count_ext;
    logic             is_full, is_empty, at_last, out_free, shift_more, accept;
    logic [CNT_W-1:0] count_m1;
    logic [IDX_W-1:0] ins_pos, src_idx;
    cal_pkg::action_t in_act;
    logic [WORD_BITS+cal_pkg::DATA_W-1:0] in_word_wide, out_word_wide;
    logic [IDX_W+cal_pkg::IDXO_W-1:0]     out_idx_wide;
    logic [CNT_W+cal_pkg::CNTO_W-1:0]     out_cnt_wide;

    assign limit_ext = CMP_W'(limit_reg);
    assign cap_ext   = CMP_W'(CAPACITY);
    assign eff_limit = (limit_reg == '0) ? CMP_W'(1) :
                       ((limit_ext > cap_ext) ? cap_ext : limit_ext);
    assign count_ext = CMP_W'(count_reg);
    assign is_full   = (count_ext >= eff_limit);
    assign is_empty  = (count_reg == '0);
    assign count_m1  = count_reg - CNT_W'(1);
    assign at_last   = (CNT_W'(cursor_reg) == count_m1);
    assign ins_pos   = is_empty ? '0 : (cursor_reg + IDX_W'(1));

    // one adder steps the shift index up or down
    assign src_idx    = idx_reg + (up_reg ? {IDX_W{1'b1}} : IDX_W'(1));
    assign shift_more = up_reg ? (CNT_W'(idx_reg) > CNT_W'(ins_pos))
                               : ((CNT_W'(idx_reg) + CNT_W'(1)) < count_reg);

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign in_act   = cal_pkg::action_t'(s_tuser);

    assign in_word_wide  = {{WORD_BITS{1'b0}}, s_tdata};
    assign out_word_wide = {{cal_pkg::DATA_W{1'b0}}, ram_rdata};
    assign out_idx_wide  = {{cal_pkg::IDXO_W{1'b0}}, cursor_reg};
    assign out_cnt_wide  = {{cal_pkg::CNTO_W{1'b0}}, count_reg};

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            cal_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = cal_pkg::ST_FETCH;
                    if (in_act == cal_pkg::ACT_INSERT && !is_full) begin
                        state_next = cal_pkg::ST_SHIFT_RD;
                    end else if (in_act == cal_pkg::ACT_REMOVE && !is_empty) begin
                        state_next = cal_pkg::ST_SHIFT_RD;
                    end else if (in_act == cal_pkg::ACT_REPLACE && !is_empty) begin
                        state_next = cal_pkg::ST_WRITE;
                    end
                end
            end
            cal_pkg::ST_SHIFT_RD: begin
                if (shift_more) begin
                    state_next = cal_pkg::ST_SHIFT_WR;
                end else if (up_reg) begin
                    state_next = cal_pkg::ST_WRITE;
                end else begin
                    state_next = cal_pkg::ST_FETCH;
                end
            end
            cal_pkg::ST_SHIFT_WR: state_next = cal_pkg::ST_SHIFT_RD;
            cal_pkg::ST_WRITE:    state_next = cal_pkg::ST_FETCH;
            cal_pkg::ST_FETCH:    state_next = cal_pkg::ST_LOAD;
            cal_pkg::ST_LOAD: begin
                if (out_free) begin
                    state_next = cal_pkg::ST_IDLE;
                end
            end
            default: state_next = cal_pkg::ST_IDLE;
        endcase
    end

    // ---------------- datapath and RAM control ----------------
    always_comb begin
        act_next     = act_reg;
        status_next  = status_reg;
        word_next    = word_reg;
        count_next   = count_reg;
        cursor_next  = cursor_reg;
        idx_next     = idx_reg;
        up_next      = up_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        ram_we       = 1'b0;
        ram_waddr    = idx_reg;
        ram_wdata    = ram_rdata;
        ram_raddr    = cursor_reg;

        unique case (state_reg)
            cal_pkg::ST_IDLE: begin
                if (accept) begin
                    act_next    = in_act;
                    word_next   = in_word_wide[WORD_BITS-1:0];
                    status_next = cal_pkg::STS_DONE;
                    unique case (in_act)
                        cal_pkg::ACT_INSERT: begin
                            if (is_full) begin
                                status_next = cal_pkg::STS_FULL;
                            end else begin
                                idx_next = count_reg[IDX_W-1:0];
                                up_next  = 1'b1;
                            end
                        end
                        cal_pkg::ACT_REMOVE: begin
                            if (is_empty) begin
                                status_next = cal_pkg::STS_EMPTY;
                            end else begin
                                idx_next = cursor_reg;
                                up_next  = 1'b0;
                            end
                        end
                        cal_pkg::ACT_REPLACE: begin
                            if (is_empty) begin
                                status_next = cal_pkg::STS_EMPTY;
                            end
                        end
                        cal_pkg::ACT_CLEAR: begin
                            count_next  = '0;
                            cursor_next = '0;
                        end
                        cal_pkg::ACT_BEGIN: begin
                            if (is_empty) begin
                                status_next = cal_pkg::STS_EMPTY;
                            end else begin
                                cursor_next = '0;
                            end
                        end
                        cal_pkg::ACT_END: begin
                            if (is_empty) begin
                                status_next = cal_pkg::STS_EMPTY;
                            end else begin
                                cursor_next = count_m1[IDX_W-1:0];
                            end
                        end
                        cal_pkg::ACT_NEXT: begin
                            if (is_empty) begin
                                status_next = cal_pkg::STS_EMPTY;
                            end else if (at_last) begin
                                status_next = cal_pkg::STS_BOUND;
                            end else begin
                                cursor_next = cursor_reg + IDX_W'(1);
                            end
                        end
                        cal_pkg::ACT_PRIOR: begin
                            if (is_empty) begin
                                status_next = cal_pkg::STS_EMPTY;
                            end else if (cursor_reg == '0) begin
                                status_next = cal_pkg::STS_BOUND;
                            end else begin
                                cursor_next = cursor_reg - IDX_W'(1);
                            end
                        end
                        default: ;  // read only and unused codes
                    endcase
                end
            end
            cal_pkg::ST_SHIFT_RD: begin
                ram_raddr = src_idx;
                if (!shift_more && !up_reg) begin
                    // removal finished
                    if (at_last) begin
                        cursor_next = '0;
                    end
                    count_next = count_m1;
                end
            end
            cal_pkg::ST_SHIFT_WR: begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = ram_rdata;
                idx_next  = src_idx;
            end
            cal_pkg::ST_WRITE: begin
                ram_we    = 1'b1;
                ram_wdata = word_reg;
                if (act_reg == cal_pkg::ACT_INSERT) begin
                    ram_waddr   = ins_pos;
                    cursor_next = ins_pos;
                    count_next  = count_reg + CNT_W'(1);
                end else begin
                    ram_waddr = cursor_reg;
                end
            end
            cal_pkg::ST_FETCH: begin
                ram_raddr = cursor_reg;
            end
            cal_pkg::ST_LOAD: begin
                ram_raddr = cursor_reg;  // hold so read data stays valid
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_user_next  = status_reg;
                    m_data_next  = '0;
                    m_data_next[cal_pkg::M_CNT_LSB +: cal_pkg::CNTO_W] =
                        out_cnt_wide[cal_pkg::CNTO_W-1:0];
                    m_data_next[cal_pkg::M_EMPTY_BIT] = is_empty;
                    m_data_next[cal_pkg::M_FULL_BIT]  = is_full;
                    if (!is_empty) begin
                        m_data_next[cal_pkg::M_WORD_LSB +: cal_pkg::DATA_W] =
                            out_word_wide[cal_pkg::DATA_W-1:0];
                        m_data_next[cal_pkg::M_IDX_LSB +: cal_pkg::IDXO_W] =
                            out_idx_wide[cal_pkg::IDXO_W-1:0];
                    end
                end
            end
            default: ;
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= cal_pkg::ST_IDLE;
            count_reg   <= '0;
            cursor_reg  <= '0;
            limit_reg   <= cal_pkg::LIMIT_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            cursor_reg  <= cursor_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        act_reg    <= act_next;
        status_reg <= status_next;
        word_reg   <= word_next;
        idx_reg    <= idx_next;
        up_reg     <= up_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    cal_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign s_tready = (state_reg == cal_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

@@ hdl/cal_checker.sv @@
module cal_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [cal_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [cal_pkg::STS_W-1:0]      m_tuser
);

    // one command in flight: no second accept right after one
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("command accepted while previous one in progress");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed under stall");

    // empty list reports zero count, cursor and word
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[cal_pkg::M_EMPTY_BIT]) |->
        (m_tdata[cal_pkg::M_EMPTY_BIT-1:0] == '0))
        else $error("empty list with nonzero fields");

    // empty list never reports a boundary status
    a_empty_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[cal_pkg::M_EMPTY_BIT]) |->
        (m_tuser != cal_pkg::STS_BOUND))
        else $error("boundary status on empty list");

    // no result straight out of reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind cursor_array_list cal_checker u_cal_checker (.*);

@@ tb/sv/tb_cursor_array_list.sv @@
`timescale 1ns / 1ps

module tb_cursor_array_list;

    localparam int LIST_DEPTH = 16;
    // command codes past ACT_READ: the block treats them as read only
    localparam logic [3:0] ACT_SPARE_LO = 4'd9;
    localparam logic [3:0] ACT_SPARE_HI = 4'd15;
    localparam int NUM_PHASES = 12;
    localparam int PHASE_WORDS = 162;

    // one command word: action in s_tuser, data word in s_tdata
    typedef struct packed {
        logic [3:0]  act;
        logic [31:0] word;
    } list_cmd_t;

    // one result word as the block should report it
    typedef struct {
        cal_pkg::status_t sts;
        logic [31:0]      word;
        logic [3:0]       idx;
        logic [4:0]       cnt;
        logic             empty;
        logic             full;
    } list_view_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [cal_pkg::LIMIT_W-1:0]     cfg_wr_data = '0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [cal_pkg::S_TDATA_W-1:0]   s_tdata = '0;
    logic [cal_pkg::ACT_W-1:0]       s_tuser = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [cal_pkg::M_TDATA_W-1:0]   m_tdata;
    logic [cal_pkg::STS_W-1:0]       m_tuser;

    // commands waiting to go out; front word is the one on the bus
    list_cmd_t  cmd_q[$];
    // predicted result words, oldest first
    list_view_t view_q[$];
    int         fail_cnt = 0;
    // when set, neither side idles
    logic       calm = 1'b0;

    // shadow copy of the list
    logic [31:0]                 lst_entries[LIST_DEPTH];
    int                          lst_count = 0;
    int                          lst_cursor = 0;
    logic [cal_pkg::LIMIT_W-1:0] lst_limit = cal_pkg::LIMIT_RESET;

    cursor_array_list #(
        .CAPACITY  (LIST_DEPTH),
        .WORD_BITS (32)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),   // [31:0] data_word
        .s_tuser     (s_tuser),   // [3:0] action
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),   // [31:0] word, [35:32] idx, [40:36] count, [41] empty, [42] full
        .m_tuser     (m_tuser)    // [1:0] status
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Apply one command to the shadow list and return what the block must report.
    function automatic list_view_t apply_command(logic [3:0] act, logic [31:0] w);
        list_view_t v;
        int lim;
        int i;
        // limit is clamped to 1..depth; 0 acts as 1
        lim = (lst_limit == 0) ? 1 : ((lst_limit > LIST_DEPTH) ? LIST_DEPTH : int'(lst_limit));
        v.sts = cal_pkg::STS_DONE;
        case (act)
            cal_pkg::ACT_INSERT: begin
                if (lst_count >= lim) begin
                    v.sts = cal_pkg::STS_FULL;
                end else if (lst_count == 0) begin
                    lst_entries[0] = w;
                    lst_cursor = 0;
                    lst_count = 1;
                end else begin
                    // open a slot right after the cursor
                    for (i = lst_count; i > lst_cursor + 1; i--)
                        lst_entries[i] = lst_entries[i-1];
                    lst_entries[lst_cursor+1] = w;
                    lst_cursor++;
                    lst_count++;
                end
            end
            cal_pkg::ACT_REMOVE: begin
                if (lst_count == 0) begin
                    v.sts = cal_pkg::STS_EMPTY;
                end else begin
                    for (i = lst_cursor; i + 1 < lst_count; i++)
                        lst_entries[i] = lst_entries[i+1];
                    // removing the tail wraps the cursor to the head
                    if (lst_cursor == lst_count - 1)
                        lst_cursor = 0;
                    lst_count--;
                end
            end
            cal_pkg::ACT_REPLACE: begin
                if (lst_count == 0)
                    v.sts = cal_pkg::STS_EMPTY;
                else
                    lst_entries[lst_cursor] = w;
            end
            cal_pkg::ACT_CLEAR: begin
                lst_count = 0;
                lst_cursor = 0;
            end
            cal_pkg::ACT_BEGIN: begin
                if (lst_count == 0)
                    v.sts = cal_pkg::STS_EMPTY;
                else
                    lst_cursor = 0;
            end
            cal_pkg::ACT_END: begin
                if (lst_count == 0)
                    v.sts = cal_pkg::STS_EMPTY;
                else
                    lst_cursor = lst_count - 1;
            end
            cal_pkg::ACT_NEXT: begin
                if (lst_count == 0)
                    v.sts = cal_pkg::STS_EMPTY;
                else if (lst_cursor == lst_count - 1)
                    v.sts = cal_pkg::STS_BOUND;
                else
                    lst_cursor++;
            end
            cal_pkg::ACT_PRIOR: begin
                if (lst_count == 0)
                    v.sts = cal_pkg::STS_EMPTY;
                else if (lst_cursor == 0)
                    v.sts = cal_pkg::STS_BOUND;
                else
                    lst_cursor--;
            end
            default: ;
        endcase
        v.word  = (lst_count == 0) ? 32'd0 : lst_entries[lst_cursor];
        v.idx   = (lst_count == 0) ? 4'd0 : 4'(lst_cursor);
        v.cnt   = 5'(lst_count);
        v.empty = (lst_count == 0);
        v.full  = (lst_count >= lim);
        return v;
    endfunction

    // Driver: hold a word until taken, then maybe idle, then present the next.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                // handshake at this edge: predict from what was on the bus
                view_q.insert(view_q.size(), apply_command(s_tuser, s_tdata));
                void'(cmd_q.pop_front());
            end
            if (cmd_q.size() != 0 && (calm || $urandom_range(99) >= 30)) begin
                s_tvalid <= 1'b1;
                s_tuser  <= cmd_q[0].act;
                s_tdata  <= cmd_q[0].word;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            fail_cnt++;
        end
    endtask

    // Monitor: random backpressure, compare each result word with the oldest prediction.
    always @(posedge aclk) begin
        list_view_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (view_q.size() == 0) begin
                    $error("result word with nothing expected: tuser %0h tdata %0h",
                           m_tuser, m_tdata);
                    fail_cnt++;
                end else begin
                    want = view_q.pop_front();
                    check_field("status", 32'(want.sts), 32'(m_tuser));
                    check_field("cursor_word", want.word,
                                m_tdata[cal_pkg::M_WORD_LSB +: cal_pkg::DATA_W]);
                    check_field("cursor_index", 32'(want.idx),
                                32'(m_tdata[cal_pkg::M_IDX_LSB +: cal_pkg::IDXO_W]));
                    check_field("entry_count", 32'(want.cnt),
                                32'(m_tdata[cal_pkg::M_CNT_LSB +: cal_pkg::CNTO_W]));
                    check_field("list_empty", 32'(want.empty),
                                32'(m_tdata[cal_pkg::M_EMPTY_BIT]));
                    check_field("list_full", 32'(want.full),
                                32'(m_tdata[cal_pkg::M_FULL_BIT]));
                end
            end
            m_tready <= calm || ($urandom_range(99) >= 30);
        end
    end

    // Append one command word to the pending queue.
    task automatic queue_cmd(logic [3:0] act, logic [31:0] w);
        list_cmd_t c;
        c.act  = act;
        c.word = w;
        cmd_q.insert(cmd_q.size(), c);
    endtask

    // Wait for every queued word to be taken and answered, then let the
    // block fall back to idle before touching the limit register.
    task automatic drain_and_settle();
        while (cmd_q.size() != 0 || view_q.size() != 0)
            @(negedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_limit(logic [cal_pkg::LIMIT_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        lst_limit = value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Weighted command pick; ins_pct / rem_pct steer the list toward full or empty.
    function automatic logic [3:0] pick_action(int ins_pct, int rem_pct);
        int r;
        if ($urandom_range(99) < ins_pct)
            return cal_pkg::ACT_INSERT;
        if ($urandom_range(99) < rem_pct)
            return cal_pkg::ACT_REMOVE;
        r = $urandom_range(39);
        if (r == 0)
            return cal_pkg::ACT_CLEAR;
        if (r < 3)
            return 4'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
        if (r < 9)
            return cal_pkg::ACT_REPLACE;
        if (r < 13)
            return cal_pkg::ACT_BEGIN;
        if (r < 17)
            return cal_pkg::ACT_END;
        if (r < 26)
            return cal_pkg::ACT_NEXT;
        if (r < 35)
            return cal_pkg::ACT_PRIOR;
        return cal_pkg::ACT_READ;
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Stimulus: directed corner cases, then random phases at several limits.
    initial begin
        int limits[NUM_PHASES];
        int ins_pct;
        int rem_pct;
        limits = '{16, 1, 0, 31, 4, 17, 16, 2, 9, 16, 12, 30};
        limits[10] = $urandom_range(31);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        write_limit(cal_pkg::LIMIT_RESET);
        @(negedge aclk);
        // empty list: every command that needs an entry is refused
        queue_cmd(cal_pkg::ACT_READ,    32'h1111_1111);
        queue_cmd(cal_pkg::ACT_REMOVE,  32'h2222_2222);
        queue_cmd(cal_pkg::ACT_REPLACE, 32'h3333_3333);
        queue_cmd(cal_pkg::ACT_BEGIN,   32'h0);
        queue_cmd(cal_pkg::ACT_END,     32'h0);
        queue_cmd(cal_pkg::ACT_NEXT,    32'h0);
        queue_cmd(cal_pkg::ACT_PRIOR,   32'h0);
        queue_cmd(cal_pkg::ACT_CLEAR,   32'h0);   // clear on empty is still done
        queue_cmd(ACT_SPARE_LO,         32'hDEAD_BEEF);
        // build a short list, walk it into both ends
        queue_cmd(cal_pkg::ACT_INSERT,  32'h0000_0000);
        queue_cmd(cal_pkg::ACT_INSERT,  32'hFFFF_FFFF);
        queue_cmd(cal_pkg::ACT_INSERT,  32'hA5A5_A5A5);
        queue_cmd(cal_pkg::ACT_PRIOR,   32'h0);
        queue_cmd(cal_pkg::ACT_PRIOR,   32'h0);
        queue_cmd(cal_pkg::ACT_PRIOR,   32'h0);   // already at head
        queue_cmd(cal_pkg::ACT_NEXT,    32'h0);
        queue_cmd(cal_pkg::ACT_END,     32'h0);
        queue_cmd(cal_pkg::ACT_NEXT,    32'h0);   // already at tail
        queue_cmd(cal_pkg::ACT_BEGIN,   32'h0);
        queue_cmd(cal_pkg::ACT_REPLACE, 32'h1234_5678);
        queue_cmd(cal_pkg::ACT_INSERT,  32'h5A5A_5A5A);  // insert in the middle, shifts up
        queue_cmd(cal_pkg::ACT_REMOVE,  32'h0);          // remove in the middle, shifts down
        queue_cmd(cal_pkg::ACT_END,     32'h0);
        queue_cmd(cal_pkg::ACT_REMOVE,  32'h0);          // tail removal wraps cursor
        queue_cmd(ACT_SPARE_HI,         32'hFFFF_FFFF);
        drain_and_settle();

        // random phases; list is kept across phases so a lowered limit can
        // land below the current count
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_limit(5'(limits[p]));
            case (p % 3)
                0: begin ins_pct = 50; rem_pct = 10; end   // fill toward full
                1: begin ins_pct = 30; rem_pct = 30; end
                default: begin ins_pct = 15; rem_pct = 45; end   // drain toward empty
            endcase
            calm = (p == 6);
            @(negedge aclk);
            for (int k = 0; k < PHASE_WORDS; k++)
                queue_cmd(pick_action(ins_pct, rem_pct), pick_word());
            drain_and_settle();
        end
        calm = 1'b0;

        // catch any stray result word after the last one
        repeat (40) @(posedge aclk);
        if (fail_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // watchdog: ends a hung run with a failure
    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule
